// ===== rtl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg: shared definitions for the key/value text tokenizer
// Character constants, event encoding and the per-byte event bundle.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int KVT_QUEUE_DEPTH = 4;
  localparam int KVT_MAX_EVENTS  = 3;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    EV_OPEN  = 2'd0,
    EV_CLOSE = 2'd1,
    EV_CHAR  = 2'd2,
    EV_END   = 2'd3
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] ch;
  } event_t;

  typedef struct packed {
    logic [1:0]   cnt;
    event_t [2:0] ev;
  } bundle_t;

  function automatic logic is_space(logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic bundle_t push_ev(bundle_t b, ev_kind_t k, logic [7:0] c);
    bundle_t r;
    r = b;
    if (b.cnt != 2'd3) begin
      r.ev[b.cnt].kind = k;
      r.ev[b.cnt].ch   = (k == EV_CHAR) ? c : 8'h00;
      r.cnt            = b.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/kvt_front.sv =====
// ----------------------------------------------------------------------------
// kvt_front: byte classifier and scan mode tracker
// Accepts one text byte per transaction and forms the bundle of events it causes.
// ----------------------------------------------------------------------------
module kvt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_text_byte,
  input  logic            in_end_of_text,
  input  logic            q_full,
  output logic            q_push,
  output kvt_pkg::bundle_t q_push_data
);
  import kvt_pkg::*;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_WORD    = 6'b000010,
    MODE_SLASH   = 6'b000100,
    MODE_COMMENT = 6'b001000,
    MODE_QUOTE   = 6'b010000,
    MODE_QESC    = 6'b100000
  } mode_t;

  mode_t   mode_r;
  mode_t   mode_nxt;
  mode_t   mode_mid;
  bundle_t bundle;
  logic    word_byte;
  logic    accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    bundle    = '0;
    mode_mid  = mode_r;
    word_byte = 1'b0;
    unique case (mode_r)
      MODE_IDLE: begin
        if (is_space(in_text_byte)) begin
          mode_mid = MODE_IDLE;
        end else if (in_text_byte == CH_SLASH) begin
          mode_mid = MODE_SLASH;
        end else if (in_text_byte == CH_LBRACE) begin
          bundle = push_ev(bundle, EV_OPEN, 8'h00);
        end else if (in_text_byte == CH_RBRACE) begin
          bundle = push_ev(bundle, EV_CLOSE, 8'h00);
        end else if (in_text_byte == CH_QUOTE) begin
          mode_mid = MODE_QUOTE;
        end else begin
          bundle   = push_ev(bundle, EV_CHAR, in_text_byte);
          mode_mid = MODE_WORD;
        end
      end
      MODE_WORD: begin
        word_byte = 1'b1;
      end
      MODE_SLASH: begin
        if (in_text_byte == CH_SLASH) begin
          mode_mid = MODE_COMMENT;
        end else begin
          bundle    = push_ev(bundle, EV_CHAR, CH_SLASH);
          word_byte = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (in_text_byte == CH_NEWLINE) begin
          mode_mid = MODE_IDLE;
        end
      end
      MODE_QUOTE: begin
        if (in_text_byte == CH_QUOTE) begin
          bundle   = push_ev(bundle, EV_END, 8'h00);
          mode_mid = MODE_IDLE;
        end else if (in_text_byte == CH_BSLASH) begin
          mode_mid = MODE_QESC;
        end else begin
          bundle = push_ev(bundle, EV_CHAR, in_text_byte);
        end
      end
      MODE_QESC: begin
        if ((in_text_byte == CH_QUOTE) || (in_text_byte == CH_BSLASH)) begin
          bundle = push_ev(bundle, EV_CHAR, in_text_byte);
        end else begin
          bundle = push_ev(bundle, EV_CHAR, CH_BSLASH);
          bundle = push_ev(bundle, EV_CHAR, in_text_byte);
        end
        mode_mid = MODE_QUOTE;
      end
      default: begin
        mode_mid = MODE_IDLE;
      end
    endcase

    if (word_byte) begin
      if (is_space(in_text_byte)) begin
        bundle   = push_ev(bundle, EV_END, 8'h00);
        mode_mid = MODE_IDLE;
      end else if (in_text_byte == CH_LBRACE) begin
        bundle   = push_ev(bundle, EV_END, 8'h00);
        bundle   = push_ev(bundle, EV_OPEN, 8'h00);
        mode_mid = MODE_IDLE;
      end else if (in_text_byte == CH_RBRACE) begin
        bundle   = push_ev(bundle, EV_END, 8'h00);
        bundle   = push_ev(bundle, EV_CLOSE, 8'h00);
        mode_mid = MODE_IDLE;
      end else begin
        bundle   = push_ev(bundle, EV_CHAR, in_text_byte);
        mode_mid = MODE_WORD;
      end
    end

    mode_nxt = mode_mid;
    if (in_end_of_text) begin
      unique case (mode_mid)
        MODE_WORD, MODE_QUOTE: begin
          bundle = push_ev(bundle, EV_END, 8'h00);
        end
        MODE_SLASH: begin
          bundle = push_ev(bundle, EV_CHAR, CH_SLASH);
          bundle = push_ev(bundle, EV_END, 8'h00);
        end
        MODE_QESC: begin
          bundle = push_ev(bundle, EV_CHAR, CH_BSLASH);
          bundle = push_ev(bundle, EV_END, 8'h00);
        end
        default: begin
          bundle = bundle;
        end
      endcase
      mode_nxt = MODE_IDLE;
    end
  end

  assign q_push      = accept && (bundle.cnt != 2'd0);
  assign q_push_data = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_text) |=> (mode_r == MODE_IDLE))
    else $error("scan mode not idle after end of text");

endmodule

// ===== rtl/kvt_queue.sv =====
// ----------------------------------------------------------------------------
// kvt_queue: event bundle queue
// Small circular queue that decouples byte classification from event output.
// ----------------------------------------------------------------------------
module kvt_queue #(
  parameter int DEPTH = kvt_pkg::KVT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kvt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output kvt_pkg::bundle_t head_data,
  output logic             empty
);
  import kvt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from an empty queue");

endmodule

// ===== rtl/kvt_back.sv =====
// ----------------------------------------------------------------------------
// kvt_back: event serializer
// Sends the events of each queued bundle one per transaction and marks the last.
// ----------------------------------------------------------------------------
module kvt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  kvt_pkg::bundle_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_token_char,
  output logic             out_last_of_run
);
  import kvt_pkg::*;

  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       last;
  logic       accept;
  event_t     cur;

  assign cur             = q_head.ev[idx_r];
  assign last            = (idx_r == (q_head.cnt - 2'd1));
  assign out_valid       = !q_empty;
  assign accept          = out_valid && out_ready;
  assign q_pop           = accept && last;
  assign out_event_kind  = cur.kind;
  assign out_token_char  = cur.ch;
  assign out_last_of_run = last;

  always_comb begin
    idx_nxt = idx_r;
    if (accept) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((q_head.cnt != 2'd0) && (idx_r < q_head.cnt)))
    else $error("event index outside queued bundle");

endmodule

// ===== rtl/keyvalue_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer_unit: streaming key/value text tokenizer
// Events are registered in the queue when their byte is accepted and leave from its head.
// Throughput: one byte per cycle while the queue has room and each byte causes at most
// one event; the output sends one event per cycle while out_ready is high.
// Reset (rst_n, synchronous, active low) sets the scan mode to idle and empties the queue.
// ----------------------------------------------------------------------------
module keyvalue_text_tokenizer_unit #(
  parameter int QUEUE_DEPTH = kvt_pkg::KVT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_token_char,
  output logic       out_last_of_run
);
  import kvt_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_push_data;
  bundle_t q_head;

  kvt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_data    (q_push_data)
  );

  kvt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty)
  );

  kvt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_token_char  (out_token_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule
